@@ src/lomc_pkg.sv @@
// lomc_pkg: shared types and constants for the linear order max cut block
// no dependencies; imported by every module of the block
package lomc_pkg;

    localparam int POS_W     = 12;
    localparam int CNT_W     = 13;
    localparam int CUT_W     = 14;
    localparam int ENTRY_W   = 16;
    localparam int CUT_LIMIT = 16383;
    localparam logic [CNT_W-1:0] OBJ_COUNT_RESET = 13'd4096;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_ADD_EDGE = 1'b0,
        OP_FINISH   = 1'b1
    } t_opcode;

    // command handed from the front to the back through the queue
    typedef struct packed {
        logic             finish;
        logic             range_err;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_cmd;

    // status from the back to the front
    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

@@ src/linear_order_max_cut.sv @@
// linear_order_max_cut: top level, configuration register and wiring of front, queue and back
// depends on lomc_pkg, lomc_front, lomc_cmd_fifo, lomc_back
//
// Usage:
//  - input channel (i_valid/o_ready): i_opcode 0 adds an edge given by the
//    positions i_pos_a and i_pos_b, 1 finishes and asks for the maximum cut
//  - output channel (o_valid/i_ready): one result per finish request with
//    o_max_cut, o_unbalanced and o_range_error
//  - config channel (i_cfg_valid/o_cfg_ready): writes object_count, always
//    ready; write it only while the block is idle
//  - an edge request in the back end is a pop plus a two-entry read-modify-write
//    on the store, which has a write port and a separate read port;
//    out-of-range and self-loop edges never reach the back end
//  - for a finish request the scan walks the whole store one entry a cycle,
//    summing the first object_count entries and clearing all of them
//  - after reset the store is cleared, one entry a cycle; o_ready stays low
//    during that pass
//  - a two-entry queue lets requests be taken while the back end is busy;
//    a held result only stalls the back end when the next finish completes
module linear_order_max_cut #(
    parameter int MAX_OBJECTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_opcode,
    input  logic [lomc_pkg::POS_W-1:0]  i_pos_a,
    input  logic [lomc_pkg::POS_W-1:0]  i_pos_b,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lomc_pkg::CUT_W-1:0]  o_max_cut,
    output logic                        o_unbalanced,
    output logic                        o_range_error,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lomc_pkg::CNT_W-1:0]  i_object_count
);
    import lomc_pkg::*;

    logic [CNT_W-1:0] r_object_count;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    t_cmd             push_cmd;
    t_cmd             head;
    t_back_status     back_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_object_count <= OBJ_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_object_count <= i_object_count;
        end
    end

    lomc_front #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_pos_a        (i_pos_a),
        .i_pos_b        (i_pos_b),
        .i_object_count (r_object_count),
        .i_back_status  (back_status),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_push_cmd     (push_cmd)
    );

    lomc_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .i_pop      (pop),
        .o_head     (head)
    );

    lomc_back #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_object_count (r_object_count),
        .i_q_empty      (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_status       (back_status),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_max_cut      (o_max_cut),
        .o_unbalanced   (o_unbalanced),
        .o_range_error  (o_range_error)
    );

endmodule

@@ src/lomc_front.sv @@
// lomc_front: accepts requests, checks edge range, orders edge ends, keeps the drop flag
// depends on lomc_pkg
module lomc_front #(
    parameter int MAX_OBJECTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_opcode,
    input  logic [lomc_pkg::POS_W-1:0]  i_pos_a,
    input  logic [lomc_pkg::POS_W-1:0]  i_pos_b,
    input  logic [lomc_pkg::CNT_W-1:0]  i_object_count,
    input  lomc_pkg::t_back_status      i_back_status,
    input  logic                        i_q_full,
    output logic                        o_push,
    output lomc_pkg::t_cmd              o_push_cmd
);
    import lomc_pkg::*;

    localparam int CW   = $clog2(MAX_OBJECTS + 1);
    localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

    logic            r_range_flag;
    logic            n_range_flag;
    logic [CMPW-1:0] eff_count;
    logic [CMPW-1:0] pos_a_ext;
    logic [CMPW-1:0] pos_b_ext;
    logic            in_range;
    logic            a_below_b;
    logic            accept;

    assign eff_count = (CMPW'(i_object_count) > CMPW'(MAX_OBJECTS)) ?
                       CMPW'(MAX_OBJECTS) : CMPW'(i_object_count);
    assign pos_a_ext = CMPW'(i_pos_a);
    assign pos_b_ext = CMPW'(i_pos_b);
    assign in_range  = (pos_a_ext < eff_count) && (pos_b_ext < eff_count);
    assign a_below_b = i_pos_a < i_pos_b;

    assign o_ready = !i_back_status.clearing && !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_push       = 1'b0;
        o_push_cmd   = '0;
        n_range_flag = r_range_flag;
        if (accept) begin
            if (i_opcode == OP_FINISH) begin
                o_push               = 1'b1;
                o_push_cmd.finish    = 1'b1;
                o_push_cmd.range_err = r_range_flag;
                n_range_flag         = 1'b0;
            end else if (!in_range) begin
                n_range_flag = 1'b1;
            end else if (i_pos_a != i_pos_b) begin
                o_push        = 1'b1;
                o_push_cmd.lo = a_below_b ? i_pos_a : i_pos_b;
                o_push_cmd.hi = a_below_b ? i_pos_b : i_pos_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_flag <= 1'b0;
        end else begin
            r_range_flag <= n_range_flag;
        end
    end

endmodule

@@ src/lomc_cmd_fifo.sv @@
// lomc_cmd_fifo: short command queue between the front and the back
// depends on lomc_pkg
module lomc_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lomc_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output lomc_pkg::t_cmd o_head
);
    import lomc_pkg::*;

    t_cmd              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == QCNT_W'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_q[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/lomc_back.sv @@
// lomc_back: difference store, edge read-modify-write, prefix-sum scan and result register
// depends on lomc_pkg
module lomc_back #(
    parameter int MAX_OBJECTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lomc_pkg::CNT_W-1:0]  i_object_count,
    input  logic                        i_q_empty,
    input  lomc_pkg::t_cmd              i_head,
    output logic                        o_pop,
    output lomc_pkg::t_back_status      o_status,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lomc_pkg::CUT_W-1:0]  o_max_cut,
    output logic                        o_unbalanced,
    output logic                        o_range_error
);
    import lomc_pkg::*;

    localparam int AW   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW   = $clog2(MAX_OBJECTS + 1);
    localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;
    localparam int SW   = AW + ENTRY_W + 1;
    localparam logic [AW-1:0]        LAST_IDX  = AW'(MAX_OBJECTS - 1);
    localparam logic signed [SW-1:0] CUT_MAX_S = SW'(CUT_LIMIT);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD_LO = 8'b0000_0100,
        S_WR_LO = 8'b0000_1000,
        S_WR_HI = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_LAST  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [AW-1:0]         r_idx;
    t_cmd                  r_cmd;
    logic [ENTRY_W-1:0]    r_mem [MAX_OBJECTS];
    logic [ENTRY_W-1:0]    r_rd_data;
    logic                  r_pipe_valid;
    logic [AW-1:0]         r_pipe_idx;
    logic signed [SW-1:0]  r_sum;
    logic signed [SW-1:0]  r_best;
    logic                  r_out_valid;
    logic [CUT_W-1:0]      r_max_cut;
    logic                  r_unbalanced;
    logic                  r_range_error;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [CMPW-1:0]       eff_count;
    logic signed [SW-1:0]  entry_ext;
    logic signed [SW-1:0]  sum_next;
    logic                  in_scan;
    logic                  load_out;

    assign eff_count = (CMPW'(i_object_count) > CMPW'(MAX_OBJECTS)) ?
                       CMPW'(MAX_OBJECTS) : CMPW'(i_object_count);

    assign o_pop             = (r_state == S_IDLE) && !i_q_empty;
    assign o_status.clearing = r_state == S_CLEAR;
    assign load_out          = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        mem_raddr = r_idx;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_RD_LO: begin
                mem_raddr = AW'(r_cmd.lo);
            end
            S_WR_LO: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_cmd.lo);
                mem_wdata = r_rd_data + 1'b1;
                mem_raddr = AW'(r_cmd.hi);
            end
            S_WR_HI: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_cmd.hi);
                mem_wdata = r_rd_data - 1'b1;
            end
            S_SCAN: begin
                // read old value and clear in the same cycle
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_idx == LAST_IDX) n_state = S_IDLE;
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_head.finish ? S_SCAN : S_RD_LO;
                end
            end
            S_RD_LO: n_state = S_WR_LO;
            S_WR_LO: n_state = S_WR_HI;
            S_WR_HI: n_state = S_IDLE;
            S_SCAN:  if (r_idx == LAST_IDX) n_state = S_LAST;
            S_LAST:  n_state = S_DONE;
            S_DONE:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_pipe_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pipe_valid <= r_state == S_SCAN;
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign entry_ext = {{(SW - ENTRY_W){r_rd_data[ENTRY_W-1]}}, r_rd_data};
    assign sum_next  = r_sum + entry_ext;
    assign in_scan   = r_pipe_valid && (CMPW'(r_pipe_idx) < eff_count);

    always_ff @(posedge i_clk) begin
        r_pipe_idx <= r_idx;
        if (o_pop) begin
            r_cmd  <= i_head;
            r_sum  <= '0;
            r_best <= '0;
        end else if (in_scan) begin
            r_sum <= sum_next;
            if (sum_next > r_best) begin
                r_best <= sum_next;
            end
        end
        if (load_out) begin
            r_max_cut     <= (r_best > CUT_MAX_S) ? CUT_W'(CUT_LIMIT) : r_best[CUT_W-1:0];
            r_unbalanced  <= r_sum != '0;
            r_range_error <= r_cmd.range_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_max_cut     = r_max_cut;
    assign o_unbalanced  = r_unbalanced;
    assign o_range_error = r_range_error;

    a_pipe_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_valid |-> $past(r_state == S_SCAN))
        else $error("scan data valid without a scan read");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done step");

    a_wr_lo_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_LO) |-> $past(r_state == S_RD_LO))
        else $error("edge update without a read of the lower end");

    a_best_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_best[SW-1])
        else $error("running maximum went negative");

endmodule

@@ tb/tb_linear_order_max_cut.sv @@
// tb_linear_order_max_cut: self-checking bench for the linear order max cut block
// depends on lomc_pkg and linear_order_max_cut; holds its own cut predictor and result checker
`timescale 1ns / 100ps

module tb_linear_order_max_cut;

    import lomc_pkg::*;

    localparam int MAX_OBJ        = 4096;
    localparam int SCAN_CYCLES    = MAX_OBJ + 3;
    localparam int QUIET_CYCLES   = 64;
    localparam int HOLD_LEN       = 3 * SCAN_CYCLES + 200;
    localparam int RAND_PER_PHASE = 35;
    localparam int RUN_LIMIT      = 12_000_000;

    typedef struct packed {
        logic [CUT_W-1:0] max_cut;
        logic             unbalanced;
        logic             range_error;
    } t_cut_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_ready;
    logic              i_opcode       = OP_ADD_EDGE;
    logic [POS_W-1:0]  i_pos_a        = '0;
    logic [POS_W-1:0]  i_pos_b        = '0;
    logic              o_valid;
    logic              i_ready        = 1'b0;
    logic [CUT_W-1:0]  o_max_cut;
    logic              o_unbalanced;
    logic              o_range_error;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_object_count = '0;

    // predictor state
    logic [ENTRY_W-1:0] edge_diff [MAX_OBJ];
    logic               drop_flag = 1'b0;
    logic [CNT_W-1:0]   obj_count = OBJ_COUNT_RESET;
    t_cut_result        cut_expect_q [$];

    // stimulus control and statistics
    logic idle_en   = 1'b1;
    logic hold_tgl  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left  = 0;
    int   burst_left = 0;
    int   cycle_cnt  = 0;
    int   err_count  = 0;
    int   req_count  = 0;
    int   cut_checked = 0;
    int   cfg_writes  = 0;

    linear_order_max_cut #(
        .MAX_OBJECTS(MAX_OBJ)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_pos_a        (i_pos_a),
        .i_pos_b        (i_pos_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_max_cut      (o_max_cut),
        .o_unbalanced   (o_unbalanced),
        .o_range_error  (o_range_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_object_count (i_object_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("[linear_order_max_cut] ERROR");
            $finish;
        end
    end

    function automatic int eff_count();
        return (obj_count > MAX_OBJ) ? MAX_OBJ : int'(obj_count);
    endfunction

    // applies one accepted request to the predictor state
    function automatic void predict_cut(t_opcode op, logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        int          n;
        longint      run;
        longint      peak;
        t_cut_result res;
        n = eff_count();
        if (op == OP_ADD_EDGE) begin
            if (a >= n || b >= n) begin
                drop_flag = 1'b1;
            end else if (a != b) begin
                edge_diff[(a < b) ? a : b] += 1'b1;
                edge_diff[(a < b) ? b : a] -= 1'b1;
            end
        end else begin
            run  = 0;
            peak = 0;
            for (int i = 0; i < n; i++) begin
                run += longint'($signed(edge_diff[i]));
                if (run > peak) begin
                    peak = run;
                end
            end
            res.max_cut     = (peak > CUT_LIMIT) ? CUT_W'(CUT_LIMIT) : CUT_W'(peak);
            res.unbalanced  = (run != 0);
            res.range_error = drop_flag;
            cut_expect_q.push_back(res);
            edge_diff = '{default: '0};
            drop_flag = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(string field, int want, int got);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch %s: expected %0d, got %0d (t=%0t)", field, want, got, $time);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : cut_check
        t_cut_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (cut_expect_q.size() == 0) begin
                note_mismatch("result with no finish request pending", -1, o_max_cut);
            end else begin
                want = cut_expect_q.pop_front();
                cut_checked++;
                if (o_max_cut !== want.max_cut) begin
                    note_mismatch("max_cut", want.max_cut, o_max_cut);
                end
                if (o_unbalanced !== want.unbalanced) begin
                    note_mismatch("unbalanced", want.unbalanced, o_unbalanced);
                end
                if (o_range_error !== want.range_error) begin
                    note_mismatch("range_error", want.range_error, o_range_error);
                end
            end
        end
    end

    // result sink: random stall bursts plus a long counted hold on request
    always @(posedge i_clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            burst_left <= $urandom_range(0, 14);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_req(input t_opcode op, input logic [POS_W-1:0] a,
                            input logic [POS_W-1:0] b);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_pos_a  <= a;
        i_pos_b  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_cut(op, a, b);
        req_count++;
    endtask

    task automatic send_edge(input int a, input int b);
        send_req(OP_ADD_EDGE, POS_W'(a), POS_W'(b));
    endtask

    task automatic send_finish(input int a, input int b);
        send_req(OP_FINISH, POS_W'(a), POS_W'(b));
    endtask

    // drop valid, wait for every result and let queued edges drain
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (cut_expect_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        settle_idle();
        i_cfg_valid    <= 1'b1;
        i_object_count <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        obj_count = value;
        cfg_writes++;
    endtask

    task automatic test_directed_cases();
        // empty store, positions on a finish are don't-care
        send_finish(4095, 4095);
        send_edge(0, 4095);
        send_edge(4095, 0);
        send_edge(7, 7);
        send_edge(100, 200);
        send_edge(150, 4000);
        send_edge(4095, 4094);
        send_finish(0, 0);
        // zero scan length: every edge is dropped
        write_count(13'd0);
        send_edge(0, 0);
        send_finish(0, 0);
        // single position: self-loop ignored without a range error, anything else dropped
        write_count(13'd1);
        send_edge(0, 0);
        send_edge(0, 1);
        send_finish(0, 0);
        // count above the store size clamps the scan
        write_count(13'd8191);
        send_edge(4095, 1);
        send_edge(2, 3);
        send_finish(0, 0);
        // shrink the scan with an edge still stored: final sum nonzero
        write_count(13'd16);
        send_edge(3, 12);
        write_count(13'd8);
        send_edge(1, 2);
        send_finish(0, 0);
    endtask

    // parallel edges stacked on one gap, given in both orders, then a dropped one
    task automatic test_stacked_edges();
        write_count(13'd2);
        repeat (40) send_edge(0, 1);
        send_finish(0, 0);
        repeat (24) send_edge(1, 0);
        send_edge(1, 1);
        send_edge(0, 2);
        send_finish(0, 0);
        settle_idle();
    endtask

    // sink holds off while finish requests pile up and stall the input
    task automatic test_output_backpressure();
        write_count(13'd4);
        hold_tgl <= ~hold_tgl;
        send_finish(1, 2);
        send_edge(0, 3);
        send_finish(3, 0);
        send_edge(1, 2);
        send_edge(2, 0);
        send_finish(0, 0);
        send_edge(0, 3);
        send_finish(0, 0);
        settle_idle();
    endtask

    task automatic test_random_graphs();
        logic [CNT_W-1:0] plan [10];
        int n;
        int r;
        int p;
        int stop_at;
        plan = '{13'd4096, 13'd4095, 13'd8191, 13'd1, 13'd0, 13'd2, 13'd4097,
                 CNT_W'($urandom_range(3, 64)), CNT_W'($urandom_range(65, 4096)), 13'd4096};
        for (int ph = 0; ph < 10; ph++) begin
            write_count(plan[ph]);
            // final phase runs with no idling on either side
            if (ph == 9) begin
                idle_en <= 1'b0;
            end
            n = eff_count();
            stop_at = req_count + RAND_PER_PHASE;
            while (req_count < stop_at) begin
                repeat ($urandom_range(1, 24)) begin
                    r = $urandom_range(0, 99);
                    if (n == 0) begin
                        send_edge($urandom_range(0, 4095), $urandom_range(0, 4095));
                    end else if (r < 78) begin
                        send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
                    end else if (r < 86) begin
                        p = $urandom_range(0, n - 1);
                        send_edge(p, p);
                    end else if (r < 95 && n < MAX_OBJ) begin
                        p = $urandom_range(4095, n);
                        if ($urandom_range(0, 1)) begin
                            send_edge(p, $urandom_range(0, 4095));
                        end else begin
                            send_edge($urandom_range(0, n - 1), p);
                        end
                    end else begin
                        send_finish($urandom_range(0, 4095), $urandom_range(0, 4095));
                    end
                end
                send_finish($urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        edge_diff = '{default: '0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_stacked_edges();
        test_output_backpressure();
        test_random_graphs();
        settle_idle();
        $display("sent %0d requests over %0d object_count settings, checked %0d cut results",
                 req_count, cfg_writes, cut_checked);
        $display("mismatches counted: %0d", err_count);
        if (err_count == 0) begin
            $display("[linear_order_max_cut] OK");
        end else begin
            $display("[linear_order_max_cut] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/lomc_pkg.sv
src/lomc_front.sv
src/lomc_cmd_fifo.sv
src/lomc_back.sv
src/linear_order_max_cut.sv
tb/tb_linear_order_max_cut.sv
